@@ rtl/wlmd_pkg.sv @@
// shared types and constants for the window local maximum detector
package wlmd_pkg;

  localparam int MAX_HALF   = 3;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 1024;
  localparam int PIXEL_BITS = 16;

  localparam int SPAN      = 2 * MAX_HALF + 1;
  localparam int HIST      = 2 * MAX_HALF;
  localparam int POS_BITS  = $clog2(MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS);
  localparam int SIZE_BITS = POS_BITS + 1;
  localparam int HALF_BITS = 2;
  localparam int CFG_BITS  = SIZE_BITS;
  localparam int LINE_BITS = HIST * PIXEL_BITS;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;
  typedef logic [POS_BITS-1:0]          pos_t;
  typedef logic [SIZE_BITS-1:0]         size_t;
  typedef logic [HALF_BITS-1:0]         half_t;
  typedef logic [LINE_BITS-1:0]         line_t;

  typedef enum logic [1:0] {
    CFG_HALF_HEIGHT = 2'd0,
    CFG_HALF_WIDTH  = 2'd1,
    CFG_IMAGE_ROWS  = 2'd2,
    CFG_IMAGE_COLS  = 2'd3
  } cfg_reg_e;

  localparam half_t RST_HALF = half_t'(1);
  localparam size_t RST_ROWS = size_t'(MAX_ROWS);
  localparam size_t RST_COLS = size_t'(MAX_COLS);

endpackage

@@ rtl/wlmd_if.sv @@
// valid/ready channel interfaces for pixels, peaks and configuration
interface wlmd_pix_if;
  logic                valid;
  logic                ready;
  wlmd_pkg::pixel_t    pixel;
  logic                frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface wlmd_peak_if;
  logic                valid;
  logic                ready;
  wlmd_pkg::size_t     peak_row;
  wlmd_pkg::size_t     peak_col;
  wlmd_pkg::pixel_t    peak_value;

  modport source (output valid, output peak_row, output peak_col, output peak_value,
                  input ready);
  modport sink   (input valid, input peak_row, input peak_col, input peak_value,
                  output ready);
endinterface

interface wlmd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       index;
  logic [wlmd_pkg::CFG_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/wlmd_ram.sv @@
// generic single write port ram with registered read
module wlmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/window_local_maximum_detector_core.sv @@
// window local maximum detector: line buffer, pixel window and peak compare
//
// Pixels come in on pixel_i in raster order, one word per handshake;
// frame_start on a word puts it at row 0, column 0. Every pixel judges the
// window centred half_height rows and half_width columns behind it. A nonzero
// centre that no window pixel exceeds leaves one word on peak_o with its
// 1-based row, column and value, in raster order of centres.
// cfg_i writes half_height, half_width, image_rows, image_cols by index; it
// is always ready. The user is to write it only while no pixel is in flight;
// the block does not enforce this. Pipeline: accept and line ram read,
// window shift and line ram write back, window compare, peak register. One
// pixel is taken every cycle unless a peak stall holds the pipeline, set by
// the single read and single write port of the line ram (a same-column write
// back is forwarded).
// When peak_o stalls, pixels that bring no peak keep flowing; a peak that
// finds the peak register full holds the compare stage and, behind it, the
// window stage and pixel_i ready.
// Reset clears the position to row 0, column 0, empties the pipeline and
// loads the default configuration; line ram and window hold no reset value.
module window_local_maximum_detector_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  wlmd_pix_if.sink          pixel_i,
  wlmd_peak_if.source       peak_o,
  wlmd_cfg_if.sink          cfg_i
);

  wlmd_pkg::half_t  half_height_q, half_width_q;
  wlmd_pkg::size_t  image_rows_q, image_cols_q;
  wlmd_pkg::pos_t   rows_last, cols_last;

  wlmd_pkg::pos_t   row_q, col_q, row_d, col_d;
  wlmd_pkg::pos_t   cur_r, cur_c;

  logic             accept;
  logic             v1_q, v2_q;
  logic             adv1, adv2;
  logic             out_free;
  logic             hit;

  wlmd_pkg::pixel_t px1_q;
  wlmd_pkg::pos_t   r1_q, c1_q, r2_q, c2_q;
  logic             byp_q;
  wlmd_pkg::line_t  byp_data_q;
  wlmd_pkg::line_t  ram_rdata, line_old, line_new;

  wlmd_pkg::pixel_t column [wlmd_pkg::SPAN];
  wlmd_pkg::pixel_t win_q [wlmd_pkg::SPAN][wlmd_pkg::SPAN];
  wlmd_pkg::pixel_t centre;

  logic             out_valid_q;
  wlmd_pkg::size_t  out_row_q, out_col_q;
  wlmd_pkg::pixel_t out_value_q;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_height_q <= wlmd_pkg::RST_HALF;
      half_width_q  <= wlmd_pkg::RST_HALF;
      image_rows_q  <= wlmd_pkg::RST_ROWS;
      image_cols_q  <= wlmd_pkg::RST_COLS;
    end else if (cfg_i.valid) begin
      unique case (wlmd_pkg::cfg_reg_e'(cfg_i.index))
        wlmd_pkg::CFG_HALF_HEIGHT: half_height_q <= cfg_i.data[wlmd_pkg::HALF_BITS-1:0];
        wlmd_pkg::CFG_HALF_WIDTH:  half_width_q  <= cfg_i.data[wlmd_pkg::HALF_BITS-1:0];
        wlmd_pkg::CFG_IMAGE_ROWS:  image_rows_q  <= cfg_i.data[wlmd_pkg::SIZE_BITS-1:0];
        wlmd_pkg::CFG_IMAGE_COLS:  image_cols_q  <= cfg_i.data[wlmd_pkg::SIZE_BITS-1:0];
      endcase
    end
  end

  // last row and column index, sizes clamped to 1 .. max
  always_comb begin
    wlmd_pkg::size_t rows_m1, cols_m1;
    rows_m1 = image_rows_q - wlmd_pkg::size_t'(1);
    cols_m1 = image_cols_q - wlmd_pkg::size_t'(1);
    if (image_rows_q == '0) begin
      rows_last = '0;
    end else if (image_rows_q > wlmd_pkg::size_t'(wlmd_pkg::MAX_ROWS)) begin
      rows_last = wlmd_pkg::pos_t'(wlmd_pkg::MAX_ROWS - 1);
    end else begin
      rows_last = rows_m1[wlmd_pkg::POS_BITS-1:0];
    end
    if (image_cols_q == '0) begin
      cols_last = '0;
    end else if (image_cols_q > wlmd_pkg::size_t'(wlmd_pkg::MAX_COLS)) begin
      cols_last = wlmd_pkg::pos_t'(wlmd_pkg::MAX_COLS - 1);
    end else begin
      cols_last = cols_m1[wlmd_pkg::POS_BITS-1:0];
    end
  end

  // pipeline control
  assign out_free      = !out_valid_q || peak_o.ready;
  assign adv2          = v2_q && (!hit || out_free);
  assign adv1          = v1_q && (!v2_q || adv2);
  assign pixel_i.ready = !v1_q || adv1;
  assign accept        = pixel_i.valid && pixel_i.ready;

  // raster position
  assign cur_r = pixel_i.frame_start ? '0 : row_q;
  assign cur_c = pixel_i.frame_start ? '0 : col_q;

  always_comb begin
    if (cur_c >= cols_last) begin
      col_d = '0;
      row_d = (cur_r >= rows_last) ? '0 : cur_r + wlmd_pkg::pos_t'(1);
    end else begin
      col_d = cur_c + wlmd_pkg::pos_t'(1);
      row_d = cur_r;
    end
  end

  // line ram: per column, the previous rows of that column
  wlmd_ram #(
    .WIDTH (wlmd_pkg::LINE_BITS),
    .DEPTH (wlmd_pkg::MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (c1_q),
    .wdata_i (line_new),
    .re_i    (accept),
    .raddr_i (cur_c),
    .rdata_o (ram_rdata)
  );

  assign line_old = byp_q ? byp_data_q : ram_rdata;

  always_comb begin
    column[0] = px1_q;
    for (int k = 0; k < wlmd_pkg::HIST; k++) begin
      column[k+1] = line_old[k*wlmd_pkg::PIXEL_BITS +: wlmd_pkg::PIXEL_BITS];
    end
    for (int k = 0; k < wlmd_pkg::HIST; k++) begin
      line_new[k*wlmd_pkg::PIXEL_BITS +: wlmd_pkg::PIXEL_BITS] = column[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (pixel_i.ready) begin
        v1_q  <= pixel_i.valid;
        byp_q <= pixel_i.valid && adv1 && (c1_q == cur_c);
      end
      if (!v2_q || adv2) begin
        v2_q <= adv1;
      end
    end
  end

  // stage payload and window shift
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q      <= pixel_i.pixel;
      r1_q       <= cur_r;
      c1_q       <= cur_c;
      byp_data_q <= line_new;
    end
    if (adv1) begin
      r2_q <= r1_q;
      c2_q <= c1_q;
      for (int dc = wlmd_pkg::SPAN - 1; dc > 0; dc--) begin
        win_q[dc] <= win_q[dc-1];
      end
      for (int dr = 0; dr < wlmd_pkg::SPAN; dr++) begin
        win_q[0][dr] <= column[dr];
      end
    end
  end

  // window compare
  assign centre = win_q[{1'b0, half_width_q}][{1'b0, half_height_q}];

  always_comb begin
    logic larger;
    logic in_frame;
    larger   = 1'b0;
    in_frame = (r2_q >= wlmd_pkg::pos_t'({half_height_q, 1'b0}))
            && (c2_q >= wlmd_pkg::pos_t'({half_width_q, 1'b0}));
    for (int dc = 0; dc < wlmd_pkg::SPAN; dc++) begin
      for (int dr = 0; dr < wlmd_pkg::SPAN; dr++) begin
        if (dc <= 2 * int'(half_width_q) && dr <= 2 * int'(half_height_q)
            && win_q[dc][dr] > centre) begin
          larger = 1'b1;
        end
      end
    end
    hit = in_frame && (centre != '0) && !larger;
  end

  // peak register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2 && hit) begin
      out_valid_q <= 1'b1;
    end else if (peak_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && hit) begin
      out_row_q   <= wlmd_pkg::size_t'(r2_q) - wlmd_pkg::size_t'(half_height_q)
                   + wlmd_pkg::size_t'(1);
      out_col_q   <= wlmd_pkg::size_t'(c2_q) - wlmd_pkg::size_t'(half_width_q)
                   + wlmd_pkg::size_t'(1);
      out_value_q <= centre;
    end
  end

  assign peak_o.valid      = out_valid_q;
  assign peak_o.peak_row   = out_row_q;
  assign peak_o.peak_col   = out_col_q;
  assign peak_o.peak_value = out_value_q;

  // checks
  a_hit_loads_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 && hit |=> out_valid_q)
    else $error("peak lost at compare stage");

  a_peak_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_value_q != '0)
    else $error("zero value reported as peak");

  a_forward_only_behind_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> v1_q)
    else $error("line forward without item in window stage");

  a_held_compare_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !adv2 |=> v2_q && $stable(r2_q) && $stable(c2_q))
    else $error("held compare stage changed");

endmodule

@@ verif/wlmd_peak_checker.sv @@
// scoreboard for the window local maximum detector: predicts peak words and checks them
module wlmd_peak_checker
  import wlmd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  wlmd_pix_if   pix_i,
  wlmd_peak_if  peak_i,
  wlmd_cfg_if   cfg_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    size_t  row;
    size_t  col;
    pixel_t value;
  } peak_word_t;

  half_t  half_height_q;
  half_t  half_width_q;
  size_t  image_rows_q;
  size_t  image_cols_q;
  int     row_pos;
  int     col_pos;
  pixel_t line_mem [MAX_COLS][HIST];
  pixel_t win_mem [SPAN][SPAN];

  peak_word_t expected_peaks [$];

  function automatic int clamp_size(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_reg_write(input cfg_reg_e idx, input logic [CFG_BITS-1:0] data);
    case (idx)
      CFG_HALF_HEIGHT: half_height_q = half_t'(data);
      CFG_HALF_WIDTH:  half_width_q  = half_t'(data);
      CFG_IMAGE_ROWS:  image_rows_q  = size_t'(data);
      CFG_IMAGE_COLS:  image_cols_q  = size_t'(data);
      default: ;
    endcase
  endfunction

  // shift the pixel into the line memory and window, then judge the finished centre
  function automatic void track_pixel(input pixel_t px, input logic new_frame);
    int         sm;
    int         sn;
    int         n_rows;
    int         n_cols;
    int         r;
    int         c;
    pixel_t     column [SPAN];
    pixel_t     centre;
    logic       is_max;
    peak_word_t w;
    sm = (int'(half_height_q) > MAX_HALF) ? MAX_HALF : int'(half_height_q);
    sn = (int'(half_width_q) > MAX_HALF) ? MAX_HALF : int'(half_width_q);
    n_rows = clamp_size(int'(image_rows_q), MAX_ROWS);
    n_cols = clamp_size(int'(image_cols_q), MAX_COLS);
    if (new_frame) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (c >= MAX_COLS) c = MAX_COLS - 1;

    column[0] = px;
    for (int k = 0; k < HIST; k++) column[k + 1] = line_mem[c][k];
    for (int k = 0; k < HIST; k++) line_mem[c][k] = column[k];
    for (int dc = SPAN - 1; dc > 0; dc--)
      for (int dr = 0; dr < SPAN; dr++) win_mem[dc][dr] = win_mem[dc - 1][dr];
    for (int dr = 0; dr < SPAN; dr++) win_mem[0][dr] = column[dr];

    if (r >= 2 * sm && c >= 2 * sn) begin
      centre = win_mem[sn][sm];
      is_max = (centre != 0);
      for (int dc = 0; dc <= 2 * sn; dc++)
        for (int dr = 0; dr <= 2 * sm; dr++)
          if (win_mem[dc][dr] > centre) is_max = 1'b0;
      if (is_max) begin
        w.row   = size_t'(r - sm + 1);
        w.col   = size_t'(c - sn + 1);
        w.value = centre;
        expected_peaks.push_back(w);
      end
    end

    if (c + 1 >= n_cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= n_rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic void check_peak(input size_t row, input size_t col, input pixel_t value);
    peak_word_t want;
    if (expected_peaks.size() == 0) begin
      if (fail_count_o < 10)
        $display("unexpected peak word: row %0d col %0d value %0d", row, col, $signed(value));
      fail_count_o++;
      return;
    end
    want = expected_peaks.pop_front();
    if (row !== want.row || col !== want.col || value !== want.value) begin
      if (fail_count_o < 10)
        $display("peak mismatch: expected row %0d col %0d value %0d, got row %0d col %0d value %0d",
                 want.row, want.col, $signed(want.value), row, col, $signed(value));
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_height_q = RST_HALF;
      half_width_q  = RST_HALF;
      image_rows_q  = RST_ROWS;
      image_cols_q  = RST_COLS;
      row_pos       = 0;
      col_pos       = 0;
      for (int i = 0; i < MAX_COLS; i++)
        for (int k = 0; k < HIST; k++) line_mem[i][k] = '0;
      for (int i = 0; i < SPAN; i++)
        for (int k = 0; k < SPAN; k++) win_mem[i][k] = '0;
      expected_peaks.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) apply_reg_write(cfg_reg_e'(cfg_i.index), cfg_i.data);
      if (pix_i.valid && pix_i.ready) track_pixel(pix_i.pixel, pix_i.frame_start);
      if (peak_i.valid && peak_i.ready)
        check_peak(peak_i.peak_row, peak_i.peak_col, peak_i.peak_value);
      pending_o = expected_peaks.size();
    end
  end

endmodule

@@ verif/tb_window_local_maximum_detector_core.sv @@
// testbench top for the window local maximum detector: stimulus, handshakes and verdict
module tb_window_local_maximum_detector_core
  import wlmd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 550;

  localparam pixel_t CORNER_IMAGE [16] = '{
    pixel_t'(-32768), pixel_t'(5),      pixel_t'(0),      pixel_t'(7),
    pixel_t'(3),      pixel_t'(32767),  pixel_t'(32767),  pixel_t'(-1),
    pixel_t'(0),      pixel_t'(-32768), pixel_t'(-5),     pixel_t'(2),
    pixel_t'(1),      pixel_t'(0),      pixel_t'(-1),     pixel_t'(0)
  };

  logic clk;
  logic rst_n;
  bit   calm;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   random_items;
  int   cols_now;

  wlmd_pix_if  pix_ch ();
  wlmd_peak_if peak_ch ();
  wlmd_cfg_if  cfg_ch ();

  window_local_maximum_detector_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pixel_i (pix_ch),
    .peak_o  (peak_ch),
    .cfg_i   (cfg_ch)
  );

  wlmd_peak_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_i        (pix_ch),
    .peak_i       (peak_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    peak_ch.ready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (peak_ch.valid && peak_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int clamp_size(input int v);
    if (v < 1) return 1;
    if (v > MAX_COLS) return MAX_COLS;
    return v;
  endfunction

  function automatic pixel_t rand_pixel(input int spread);
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) return pixel_t'(32767);
    if (pick < 8) return pixel_t'(-32768);
    if (pick < 16) return pixel_t'($urandom);
    return pixel_t'(int'($urandom_range(2 * spread)) - spread);
  endfunction

  task automatic push_pixel(input pixel_t value, input logic new_frame);
    while (!calm && $urandom_range(99) < 23) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= value;
    pix_ch.frame_start <= new_frame;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold pixels back until every peak is out and the pipeline has emptied
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_BITS'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input int sm, input int sn, input int rows, input int cols,
                            output bit frame_needed);
    settle();
    write_reg(CFG_HALF_HEIGHT, int'($urandom_range(511)) * 4 + sm);
    write_reg(CFG_HALF_WIDTH, int'($urandom_range(511)) * 4 + sn);
    write_reg(CFG_IMAGE_ROWS, rows);
    write_reg(CFG_IMAGE_COLS, cols);
    cfg_ch.valid <= 1'b0;
    // wider lines would read line memory never filled in this frame
    frame_needed = clamp_size(cols) > cols_now;
    cols_now = clamp_size(cols);
  endtask

  initial begin
    int sm;
    int sn;
    int rows;
    int cols;
    int n;
    int pick;
    int spread;
    int phase;
    bit need_fs;
    bit pause_mid;

    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_HALF_HEIGHT;
    cfg_ch.data        = '0;
    peak_ch.ready      = 1'b0;
    calm               = 1'b0;
    idle_cycles        = 0;
    random_items       = 0;
    cols_now           = MAX_COLS;
    phase              = 0;

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes and ties in a 3x3 window
    set_config(1, 1, 4, 4, need_fs);
    for (int i = 0; i < 16; i++) push_pixel(CORNER_IMAGE[i], i == 0);

    // zero sizes clamp to one pixel, single pixel window, negative maximum
    set_config(0, 0, 0, 0, need_fs);
    push_pixel(pixel_t'(-1), 1'b1);
    push_pixel(pixel_t'(0), 1'b0);
    push_pixel(pixel_t'(-32768), 1'b0);
    push_pixel(pixel_t'(1), 1'b0);

    // window wider than the image, oversize row count
    set_config(3, 3, 2047, 5, need_fs);
    for (int i = 0; i < 5; i++) push_pixel(rand_pixel(3), i == 0);

    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        sm = 0; sn = 1; rows = 1; cols = 2047; n = 40;
      end else if (phase == 1) begin
        sm = 1; sn = 1; rows = 1024; cols = 3; n = 40;
      end else begin
        sm = $urandom_range(3);
        sn = $urandom_range(3);
        pick = $urandom_range(99);
        if (pick < 4) rows = 0;
        else if (pick < 8) rows = $urandom_range(2047, 1024);
        else rows = $urandom_range(9, 1);
        pick = $urandom_range(99);
        if (pick < 4) cols = 0;
        else if (pick < 7) cols = $urandom_range(2047, 1024);
        else cols = $urandom_range(12, 1);
        n = clamp_size(rows) * clamp_size(cols) * int'($urandom_range(3, 1));
        if (n > 90) n = 90;
        if (n < 6) n = 6;
      end
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      spread = $urandom_range(6, 1);
      pause_mid = (phase == 3) || ($urandom_range(9) == 0);
      set_config(sm, sn, rows, cols, need_fs);
      for (int i = 0; i < n; i++) begin
        calm <= (random_items >= 250 && random_items < 370);
        if (pause_mid && i == n / 2) settle();
        push_pixel(rand_pixel(spread),
                   (i == 0 && (need_fs || $urandom_range(1) == 1)) ||
                   ($urandom_range(99) < 3));
        random_items++;
      end
      phase++;
    end

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ window_local_maximum_detector_core.f @@
rtl/wlmd_pkg.sv
rtl/wlmd_if.sv
rtl/wlmd_ram.sv
rtl/window_local_maximum_detector_core.sv
verif/wlmd_peak_checker.sv
verif/tb_window_local_maximum_detector_core.sv
